// ===== rtl/addressable_led_pixel_encoder_top_defines.svh =====
// Assertion macros for the addressable LED pixel encoder.
// Used by the queue and the symbol serializer; expects aclk and aresetn in scope.
`ifndef ADDRESSABLE_LED_PIXEL_ENCODER_TOP_DEFINES_SVH
`define ADDRESSABLE_LED_PIXEL_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset
`define ALPE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("alpe assertion failed");
// Checked at every edge, reset included
`define ALPE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("alpe reset assertion failed");
`else
`define ALPE_ASSERT(lbl, prop)
`define ALPE_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== rtl/alpe_pkg.sv =====
// Shared types and constants of the addressable LED pixel encoder.
// No dependencies.
package alpe_pkg;

    localparam int unsigned PIX_W       = 10;
    localparam logic [10:0] MAX_LEDS    = 11'd1024;
    localparam logic [14:0] RESET_TICKS = 15'd250;
    localparam int unsigned WORD_BITS   = 24;

    // Queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

    // Register indexes
    localparam logic [3:0] REG_SCALE_RED   = 4'd0;
    localparam logic [3:0] REG_SCALE_GREEN = 4'd1;
    localparam logic [3:0] REG_SCALE_BLUE  = 4'd2;
    localparam logic [3:0] REG_CORR_ON     = 4'd3;
    localparam logic [3:0] REG_BYTE_ORDER  = 4'd4;
    localparam logic [3:0] REG_LED_COUNT   = 4'd5;
    localparam logic [3:0] REG_SHORT_TICKS = 4'd6;
    localparam logic [3:0] REG_LONG_TICKS  = 4'd7;

    // Wire byte orders
    localparam logic [2:0] ORDER_RGB = 3'd0;
    localparam logic [2:0] ORDER_GRB = 3'd1;
    localparam logic [2:0] ORDER_BRG = 3'd2;
    localparam logic [2:0] ORDER_RBG = 3'd3;
    localparam logic [2:0] ORDER_GBR = 3'd4;
    localparam logic [2:0] ORDER_BGR = 3'd5;

    typedef struct packed {
        logic [17:0] scale_red;
        logic [17:0] scale_green;
        logic [17:0] scale_blue;
        logic        correction_on;
        logic [2:0]  byte_order;
        logic [10:0] led_count;
    } front_cfg_t;

    typedef struct packed {
        logic [14:0] short_ticks;
        logic [14:0] long_ticks;
    } back_cfg_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 frame_end;
    } entry_t;

endpackage

// ===== rtl/alpe_front.sv =====
// Front end: scales (when correction is on) and reorders one pixel, tracks frame position.
// Depends on alpe_pkg.
module alpe_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  alpe_pkg::front_cfg_t  cfg,
    input  logic                  pix_valid,
    input  logic [7:0]            pix_red,
    input  logic [7:0]            pix_green,
    input  logic [7:0]            pix_blue,
    output logic                  pix_ready,
    input  logic                  q_full,
    output logic                  q_push,
    output alpe_pkg::entry_t      q_data
);

    logic [alpe_pkg::PIX_W-1:0] pixel_index_reg, pixel_index_next;
    logic [7:0]  r_c, g_c, b_c;
    logic [alpe_pkg::WORD_BITS-1:0] word_c;
    logic [10:0] count_eff;
    logic [10:0] next_pos;
    logic        frame_end;

    // Round half up and saturate one channel
    function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [17:0] s);
        logic [26:0] prod;
        logic [10:0] v;
        prod = {1'b0, 8'(c) * 18'(s) + 26'd0} + 27'd32768;
        v    = prod[26:16];
        return (v > 11'd255) ? 8'hFF : v[7:0];
    endfunction

    assign pix_ready = !q_full;
    assign q_push    = pix_valid && !q_full;
    assign q_data    = '{word: word_c, frame_end: frame_end};

    // Correct the channels
    always_comb begin
        if (cfg.correction_on) begin
            r_c = scale_ch(pix_red, cfg.scale_red);
            g_c = scale_ch(pix_green, cfg.scale_green);
            b_c = scale_ch(pix_blue, cfg.scale_blue);
        end else begin
            r_c = pix_red;
            g_c = pix_green;
            b_c = pix_blue;
        end
    end

    // Arrange bytes in wire order
    always_comb begin
        unique case (cfg.byte_order)
            alpe_pkg::ORDER_RGB: word_c = {r_c, g_c, b_c};
            alpe_pkg::ORDER_BRG: word_c = {b_c, r_c, g_c};
            alpe_pkg::ORDER_RBG: word_c = {r_c, b_c, g_c};
            alpe_pkg::ORDER_GBR: word_c = {g_c, b_c, r_c};
            alpe_pkg::ORDER_BGR: word_c = {b_c, g_c, r_c};
            default:             word_c = {g_c, r_c, b_c};
        endcase
    end

    // Classify frame end against the clamped count
    always_comb begin
        if (cfg.led_count == 11'd0) begin
            count_eff = 11'd1;
        end else if (cfg.led_count > alpe_pkg::MAX_LEDS) begin
            count_eff = alpe_pkg::MAX_LEDS;
        end else begin
            count_eff = cfg.led_count;
        end
        next_pos         = {1'b0, pixel_index_reg} + 11'd1;
        frame_end        = (next_pos >= count_eff);
        pixel_index_next = pixel_index_reg;
        if (q_push) begin
            pixel_index_next = frame_end ? '0 : next_pos[alpe_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_index_reg <= '0;
        end else begin
            pixel_index_reg <= pixel_index_next;
        end
    end

endmodule

// ===== rtl/alpe_fifo.sv =====
// Short queue of classified pixels between front and back.
// Depends on alpe_pkg and the assertion macro header.
`include "addressable_led_pixel_encoder_top_defines.svh"
module alpe_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  alpe_pkg::entry_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output alpe_pkg::entry_t  head_data
);

    alpe_pkg::entry_t mem [alpe_pkg::FIFO_DEPTH];
    logic [alpe_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [alpe_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [alpe_pkg::FIFO_CW-1:0] count_reg, count_next;

    assign full       = (count_reg == alpe_pkg::FIFO_CW'(alpe_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store words
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `ALPE_ASSERT(a_fifo_count_bound, count_reg <= alpe_pkg::FIFO_CW'(alpe_pkg::FIFO_DEPTH))
    `ALPE_ASSERT(a_fifo_pop_nonempty, pop |-> head_valid)
    `ALPE_ASSERT(a_fifo_count_ptrs, count_reg[alpe_pkg::FIFO_AW-1:0] == (wr_ptr_reg - rd_ptr_reg))

endmodule

// ===== rtl/alpe_back.sv =====
// Back end: serializes queued pixels into pulse-width symbols.
// Depends on alpe_pkg and the assertion macro header.
`include "addressable_led_pixel_encoder_top_defines.svh"
module alpe_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  alpe_pkg::back_cfg_t cfg,
    input  logic              head_valid,
    input  alpe_pkg::entry_t  head_data,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic        busy_reg, busy_next;
    logic [alpe_pkg::WORD_BITS-1:0] word_reg, word_next;
    logic        frame_end_reg, frame_end_next;
    logic [4:0]  bit_idx_reg, bit_idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    logic        out_user_reg, out_user_next;
    logic        load;
    logic        cur_final;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // Build next symbol, pop the queue on the final symbol of a pixel or while idle
    always_comb begin
        load           = !out_valid_reg || m_tready;
        cur_final      = frame_end_reg ? (bit_idx_reg == 5'd24) : (bit_idx_reg == 5'd23);
        pop            = 1'b0;
        busy_next      = busy_reg;
        word_next      = word_reg;
        frame_end_next = frame_end_reg;
        bit_idx_next   = bit_idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        if (load) begin
            if (busy_reg) begin
                out_valid_next = 1'b1;
                out_last_next  = cur_final;
                if (bit_idx_reg == 5'd24) begin
                    out_data_next = {alpe_pkg::RESET_TICKS, 1'b0, alpe_pkg::RESET_TICKS, 1'b0};
                    out_user_next = 1'b1;
                end else if (word_reg[alpe_pkg::WORD_BITS-1]) begin
                    out_data_next = {cfg.short_ticks, 1'b0, cfg.long_ticks, 1'b1};
                    out_user_next = 1'b0;
                end else begin
                    out_data_next = {cfg.long_ticks, 1'b0, cfg.short_ticks, 1'b1};
                    out_user_next = 1'b0;
                end
                if (cur_final) begin
                    pop            = head_valid;
                    busy_next      = head_valid;
                    word_next      = head_data.word;
                    frame_end_next = head_data.frame_end;
                    bit_idx_next   = '0;
                end else begin
                    word_next    = {word_reg[alpe_pkg::WORD_BITS-2:0], 1'b0};
                    bit_idx_next = bit_idx_reg + 5'd1;
                end
            end else begin
                out_valid_next = 1'b0;
                if (head_valid) begin
                    pop            = 1'b1;
                    busy_next      = 1'b1;
                    word_next      = head_data.word;
                    frame_end_next = head_data.frame_end;
                    bit_idx_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            bit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        frame_end_reg <= frame_end_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_user_reg  <= out_user_next;
    end

    `ALPE_ASSERT(a_back_idx_bound, busy_reg |-> (bit_idx_reg <= 5'd24))
    `ALPE_ASSERT(a_back_reset_sym_last, (out_valid_reg && out_user_reg) |-> out_last_reg)
    `ALPE_ASSERT_RST(a_back_reset_clears, !aresetn |=> (!out_valid_reg && !busy_reg))

endmodule

// ===== rtl/addressable_led_pixel_encoder_top.sv =====
// Addressable LED pixel encoder: on an idle block an accepted pixel passes the queue and the
// word register to the output register. The serializer sends one symbol per cycle while the
// receiver is ready: 24 per pixel plus a reset symbol at a frame end. A four-entry queue
// lets pixels be taken while symbols go out. Synchronous active-low reset restores the
// register defaults, clears the frame position and empties the queue and output register.
module addressable_led_pixel_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [17:0] cfg_data,
    // Pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    // Symbol output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // first_level[0], first_ticks[15:1],
                                        // second_level[16], second_ticks[31:17]
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser    // frame_reset
);

    alpe_pkg::front_cfg_t fcfg_reg;
    alpe_pkg::back_cfg_t  bcfg_reg;
    logic                 q_push, q_full, q_pop, q_head_valid;
    alpe_pkg::entry_t     q_in, q_head;

    assign cfg_ready = 1'b1;

    // Register writes; indexes beyond the list drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcfg_reg.scale_red     <= 18'd65536;
            fcfg_reg.scale_green   <= 18'd26075;
            fcfg_reg.scale_blue    <= 18'd6942;
            fcfg_reg.correction_on <= 1'b1;
            fcfg_reg.byte_order    <= alpe_pkg::ORDER_GRB;
            fcfg_reg.led_count     <= 11'd12;
            bcfg_reg.short_ticks   <= 15'd3;
            bcfg_reg.long_ticks    <= 15'd9;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                alpe_pkg::REG_SCALE_RED:   fcfg_reg.scale_red     <= cfg_data;
                alpe_pkg::REG_SCALE_GREEN: fcfg_reg.scale_green   <= cfg_data;
                alpe_pkg::REG_SCALE_BLUE:  fcfg_reg.scale_blue    <= cfg_data;
                alpe_pkg::REG_CORR_ON:     fcfg_reg.correction_on <= cfg_data[0];
                alpe_pkg::REG_BYTE_ORDER:  fcfg_reg.byte_order    <= cfg_data[2:0];
                alpe_pkg::REG_LED_COUNT:   fcfg_reg.led_count     <= cfg_data[10:0];
                alpe_pkg::REG_SHORT_TICKS: bcfg_reg.short_ticks   <= cfg_data[14:0];
                alpe_pkg::REG_LONG_TICKS:  bcfg_reg.long_ticks    <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    alpe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (fcfg_reg),
        .pix_valid (s_axis_tvalid),
        .pix_red   (s_axis_tdata[7:0]),
        .pix_green (s_axis_tdata[15:8]),
        .pix_blue  (s_axis_tdata[23:16]),
        .pix_ready (s_axis_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    alpe_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head)
    );

    alpe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (bcfg_reg),
        .head_valid (q_head_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tlast    (m_axis_tlast),
        .m_tuser    (m_axis_tuser)
    );

endmodule

// ===== test/addressable_led_pixel_encoder_top_tb.sv =====
// Self-checking testbench for addressable_led_pixel_encoder_top: pixels in, pulse symbols out.
// Predicts every symbol in a small scoreboard class and checks each output word in order.
// Depends on alpe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module addressable_led_pixel_encoder_top_tb;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam logic [3:0] REG_UNUSED_FIRST = 4'd8;
    localparam logic [3:0] REG_UNUSED_LAST = 4'd15;

    typedef struct packed {
        logic        first_level;
        logic [14:0] first_ticks;
        logic        second_level;
        logic [14:0] second_ticks;
        logic        frame_reset;
        logic        run_last;
    } led_symbol_t;

    typedef enum {RX_FULL, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // Symbol predictor: shadow registers, frame position and the symbols still owed
    class pixel_symbol_model;
        logic [17:0] scale_r, scale_g, scale_b;
        logic        corr_on;
        logic [2:0]  order;
        logic [10:0] led_count;
        logic [14:0] short_t, long_t;
        int unsigned pos;
        led_symbol_t owed[$];
        int unsigned errors;

        function new();
            scale_r = 18'd65536;
            scale_g = 18'd26075;
            scale_b = 18'd6942;
            corr_on = 1'b1;
            order = alpe_pkg::ORDER_GRB;
            led_count = 11'd12;
            short_t = 15'd3;
            long_t = 15'd9;
            pos = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [3:0] idx, logic [17:0] data);
            case (idx)
                alpe_pkg::REG_SCALE_RED:   scale_r = data;
                alpe_pkg::REG_SCALE_GREEN: scale_g = data;
                alpe_pkg::REG_SCALE_BLUE:  scale_b = data;
                alpe_pkg::REG_CORR_ON:     corr_on = data[0];
                alpe_pkg::REG_BYTE_ORDER:  order = data[2:0];
                alpe_pkg::REG_LED_COUNT:   led_count = data[10:0];
                alpe_pkg::REG_SHORT_TICKS: short_t = data[14:0];
                alpe_pkg::REG_LONG_TICKS:  long_t = data[14:0];
                default: ;
            endcase
        endfunction

        // Round half up, then clamp to one byte
        function logic [7:0] scale_channel(logic [7:0] c, logic [17:0] s);
            logic [26:0] v;
            v = ({19'd0, c} * {9'd0, s} + 27'd32768) >> 16;
            return (v > 27'd255) ? 8'hFF : v[7:0];
        endfunction

        function void add_pixel(logic [23:0] data);
            logic [7:0]  r, g, b, b0, b1, b2;
            logic [23:0] bits;
            led_symbol_t sym;
            int unsigned frame_len;
            r = data[7:0];
            g = data[15:8];
            b = data[23:16];
            if (corr_on) begin
                r = scale_channel(r, scale_r);
                g = scale_channel(g, scale_g);
                b = scale_channel(b, scale_b);
            end
            case (order)
                alpe_pkg::ORDER_RGB: begin b0 = r; b1 = g; b2 = b; end
                alpe_pkg::ORDER_BRG: begin b0 = b; b1 = r; b2 = g; end
                alpe_pkg::ORDER_RBG: begin b0 = r; b1 = b; b2 = g; end
                alpe_pkg::ORDER_GBR: begin b0 = g; b1 = b; b2 = r; end
                alpe_pkg::ORDER_BGR: begin b0 = b; b1 = g; b2 = r; end
                default:             begin b0 = g; b1 = r; b2 = b; end
            endcase
            bits = {b0, b1, b2};
            // Zero count acts as one, counts past the maximum clamp
            frame_len = (led_count == 11'd0) ? 1 : int'(led_count);
            if (frame_len > int'(alpe_pkg::MAX_LEDS))
                frame_len = int'(alpe_pkg::MAX_LEDS);
            // Emit MSB first
            for (int i = 23; i >= 0; i--) begin
                sym.first_level = 1'b1;
                sym.first_ticks = bits[i] ? long_t : short_t;
                sym.second_level = 1'b0;
                sym.second_ticks = bits[i] ? short_t : long_t;
                sym.frame_reset = 1'b0;
                sym.run_last = 1'b0;
                owed.push_back(sym);
            end
            if (pos + 1 >= frame_len) begin
                sym.first_level = 1'b0;
                sym.first_ticks = alpe_pkg::RESET_TICKS;
                sym.second_level = 1'b0;
                sym.second_ticks = alpe_pkg::RESET_TICKS;
                sym.frame_reset = 1'b1;
                owed.push_back(sym);
                pos = 0;
            end else begin
                pos++;
            end
            owed[owed.size() - 1].run_last = 1'b1;
        endfunction

        function void compare(string field, int unsigned expv, int unsigned gotv);
            if (expv != gotv) begin
                errors++;
                $error("%s: expected %0d, got %0d", field, expv, gotv);
            end
        endfunction

        function void check_symbol(led_symbol_t got);
            led_symbol_t want;
            if (owed.size() == 0) begin
                errors++;
                $error("symbol word with no pixel pending: %h", got);
                return;
            end
            want = owed.pop_front();
            compare("first_level", want.first_level, got.first_level);
            compare("first_ticks", want.first_ticks, got.first_ticks);
            compare("second_level", want.second_level, got.second_level);
            compare("second_ticks", want.second_ticks, got.second_ticks);
            compare("frame_reset", want.frame_reset, got.frame_reset);
            compare("run_last", want.run_last, got.run_last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [17:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    pixel_symbol_model symbols;
    led_symbol_t got_sym;
    logic        pix_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    int unsigned cycles = 0;
    rx_mode_t    rx_mode = RX_FULL;
    int unsigned rx_phase = 0;
    int unsigned rx_period = 5;
    int unsigned rx_hold = 2;
    bit          tx_gaps_on = 1'b0;
    int unsigned tx_burst_left = 0;

    addressable_led_pixel_encoder_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // Sample handshakes, feed the predictor, check symbols, guard the run length
    always @(posedge aclk) begin
        cycles++;
        pix_taken = aresetn && s_axis_tvalid && s_axis_tready;
        cfg_taken = aresetn && cfg_valid && cfg_ready;
        if (pix_taken)
            symbols.add_pixel(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_sym.first_level = m_axis_tdata[0];
            got_sym.first_ticks = m_axis_tdata[15:1];
            got_sym.second_level = m_axis_tdata[16];
            got_sym.second_ticks = m_axis_tdata[31:17];
            got_sym.frame_reset = m_axis_tuser;
            got_sym.run_last = m_axis_tlast;
            symbols.check_symbol(got_sym);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output backpressure
    always @(negedge aclk) begin
        case (rx_mode)
            RX_FULL:   m_axis_tready = 1'b1;
            RX_RANDOM: m_axis_tready = ($urandom_range(99) < 55);
            default: begin
                rx_phase = (rx_phase + 1) % rx_period;
                m_axis_tready = (rx_phase >= rx_hold);
            end
        endcase
    end

    // All tasks are entered and left at a falling edge
    task automatic write_reg(input logic [3:0] idx, input logic [17:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid = 1'b0;
        symbols.set_reg(idx, data);
    endtask

    task automatic send_pixel(input logic [23:0] pix);
        if (tx_gaps_on && tx_burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            tx_burst_left = $urandom_range(1, 16);
        end
        if (tx_burst_left > 0)
            tx_burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata = pix;
        do @(negedge aclk); while (!pix_taken);
    endtask

    // Hold the input until every owed symbol is out, then let the pipe settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (symbols.owed.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_channel();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return 8'h00;
        if (sel < 24)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [17:0] pick_scale();
        case ($urandom_range(5))
            0: return 18'd0;
            1: return 18'h3FFFF;
            2: return 18'd65536;
            default: return 18'($urandom_range(262143));
        endcase
    endfunction

    function automatic logic [14:0] pick_ticks();
        case ($urandom_range(5))
            0: return 15'd0;
            1: return 15'd1;
            2: return 15'h7FFF;
            default: return 15'($urandom_range(32767));
        endcase
    endfunction

    function automatic logic [10:0] pick_count();
        case ($urandom_range(9))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd2;
            3: return 11'd3;
            4: return 11'd12;
            5: return 11'd1024;
            6: return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(4, 40));
        endcase
    endfunction

    // Retune every register (junk above the narrow fields), poke an unused index, then stream random pixels
    task automatic random_phase(input int unsigned count, input bit pause_midway);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(alpe_pkg::REG_SCALE_RED, pick_scale());
        write_reg(alpe_pkg::REG_SCALE_GREEN, pick_scale());
        write_reg(alpe_pkg::REG_SCALE_BLUE, pick_scale());
        write_reg(alpe_pkg::REG_CORR_ON, {junk[16:0], 1'($urandom_range(1))});
        write_reg(alpe_pkg::REG_BYTE_ORDER, {junk[14:0], 3'($urandom_range(7))});
        write_reg(alpe_pkg::REG_LED_COUNT, {junk[6:0], pick_count()});
        write_reg(alpe_pkg::REG_SHORT_TICKS, {junk[2:0], pick_ticks()});
        write_reg(alpe_pkg::REG_LONG_TICKS, {junk[5:3], pick_ticks()});
        write_reg(4'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), 18'($urandom()));
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2)
                drain();
            send_pixel({pick_channel(), pick_channel(), pick_channel()});
        end
        drain();
    endtask

    initial begin
        symbols = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Register defaults: extremes and walking patterns
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h0000FF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF0000);
        send_pixel(24'h55AA80);
        drain();

        // Every byte order, raw colors, one pixel per frame, zero and maximum pulses
        write_reg(alpe_pkg::REG_CORR_ON, 18'd0);
        write_reg(alpe_pkg::REG_LED_COUNT, 18'd0);
        write_reg(alpe_pkg::REG_SHORT_TICKS, 18'd0);
        write_reg(alpe_pkg::REG_LONG_TICKS, 18'h7FFF);
        for (int ord = 0; ord < 8; ord++) begin
            write_reg(alpe_pkg::REG_BYTE_ORDER, 18'(ord));
            send_pixel(24'h81_3C_F0);
            drain();
        end

        // Scaling at the rounding boundary, zero and full-scale factors
        write_reg(alpe_pkg::REG_CORR_ON, 18'd1);
        write_reg(alpe_pkg::REG_LED_COUNT, 18'd1);
        write_reg(alpe_pkg::REG_BYTE_ORDER, 18'(alpe_pkg::ORDER_RGB));
        write_reg(alpe_pkg::REG_SHORT_TICKS, 18'd1);
        write_reg(alpe_pkg::REG_LONG_TICKS, 18'd2);
        write_reg(alpe_pkg::REG_SCALE_RED, 18'd32768);
        write_reg(alpe_pkg::REG_SCALE_GREEN, 18'd32767);
        write_reg(alpe_pkg::REG_SCALE_BLUE, 18'd0);
        send_pixel(24'h010101);
        send_pixel(24'hFFFFFF);
        drain();
        write_reg(alpe_pkg::REG_SCALE_RED, 18'h3FFFF);
        write_reg(alpe_pkg::REG_SCALE_GREEN, 18'h3FFFF);
        write_reg(alpe_pkg::REG_SCALE_BLUE, 18'h3FFFF);
        send_pixel(24'h8001FF);
        drain();

        // Frame length cut below the current position ends the frame on the next pixel
        write_reg(alpe_pkg::REG_LED_COUNT, 18'd12);
        repeat (5) send_pixel({pick_channel(), pick_channel(), pick_channel()});
        drain();
        write_reg(alpe_pkg::REG_LED_COUNT, 18'd3);
        write_reg(REG_UNUSED_FIRST, 18'h3FFFF);
        write_reg(REG_UNUSED_LAST, 18'd1);
        send_pixel(24'h123456);
        drain();

        // Oversized count clamps to the maximum frame: no frame end within a short run
        write_reg(alpe_pkg::REG_LED_COUNT, 18'h3FFFF);
        rx_mode = RX_FULL;
        for (int i = 0; i < 20; i++)
            send_pixel(24'($urandom()));
        drain();

        // Random phases under varied sender and receiver idling
        for (int ph = 0; ph < 6; ph++) begin
            tx_gaps_on = (ph % 3 != 0);
            tx_burst_left = 0;
            rx_period = $urandom_range(2, 9);
            rx_hold = $urandom_range(1, rx_period - 1);
            case (ph % 3)
                0: rx_mode = RX_FULL;
                1: rx_mode = RX_RANDOM;
                default: rx_mode = RX_PATTERN;
            endcase
            if (ph == 5)
                rx_mode = RX_RANDOM;
            random_phase(40, ph == 2);
        end

        if (symbols.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
